// ===== hdl/idfl_pkg.sv =====
package idfl_pkg;

	localparam int ID_W = 8;
	localparam int OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_FIND  = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

endpackage

// ===== hdl/idfl_req_if.sv =====
interface idfl_req_if import idfl_pkg::*;;
	logic            valid;
	logic            ready;
	op_t             operation;
	logic [ID_W-1:0] id;

	modport source(output valid, operation, id, input ready);
	modport sink(input valid, operation, id, output ready);
endinterface

// ===== hdl/idfl_rsp_if.sv =====
interface idfl_rsp_if import idfl_pkg::*;;
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] result_id;
	logic            ok;

	modport source(output valid, result_id, ok, input ready);
	modport sink(input valid, result_id, ok, output ready);
endinterface

// ===== hdl/idfl_link_ram.sv =====
module idfl_link_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int LW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/id_free_list_allocator.sv =====
// identifier allocator: hands out ids 1..NUM_IDS from a free list threaded
// through a link memory (entry 0 is the list head, NUM_IDS+1 entries)
//
// req channel (idfl_req_if, sink): operation and id; one request is taken at
// a time, req.ready is high only while the block is idle
// rsp channel (idfl_rsp_if, source): result_id and ok, exactly one response
// per request, in request order
//
// steps, from acceptance to the response register being loaded: allocate
// reads the head, reads its link, writes that link as the new head, marks
// the popped id; free reads the id's entry, reads the head, links the id to
// it, writes the id as head; check reads the id's entry; find scans upward
// from entry 0 to the lowest allocated entry; the link memory has registered
// reads and one write port, so each list update writes two entries in turn
//
// after arst_n is released a clearing pass writes the initial chain into
// the link memory, writing one entry per cycle; req.ready stays low
// during the pass
// the response sits in an output register; a new request is accepted while
// it waits, and the block holds the next result internally until rsp.ready
module id_free_list_allocator import idfl_pkg::*; #(
	parameter int NUM_IDS = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	idfl_req_if.sink   req,
	idfl_rsp_if.source rsp
);

	localparam int DEPTH = NUM_IDS + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(NUM_IDS + 3);
	localparam int IW    = (AW > ID_W) ? AW : ID_W;

	localparam logic [LW-1:0] END_MARK   = LW'(NUM_IDS + 1);
	localparam logic [LW-1:0] ALLOC_MARK = LW'(NUM_IDS + 2);
	localparam logic [LW-1:0] MAX_LINK   = LW'(NUM_IDS);
	localparam logic [AW-1:0] LAST_IDX   = AW'(NUM_IDS);
	localparam logic [IW-1:0] MAX_ID     = IW'(NUM_IDS);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_LOOKUP = 9'b000000100,
		ST_LINK   = 9'b000001000,
		ST_MARK   = 9'b000010000,
		ST_HEADRD = 9'b000100000,
		ST_PUSH   = 9'b001000000,
		ST_SCAN   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	op_t           op_q;
	logic [AW-1:0] id_addr_q;
	logic          id_ok_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] rd_addr_s1;

	logic            out_valid_q;
	logic [ID_W-1:0] out_res_q;
	logic            out_ok_q;
	logic [ID_W-1:0] pend_res_q;
	logic            pend_ok_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [LW-1:0] wdata, rdata;

	logic            fin, fin_ok, slot_free;
	logic [ID_W-1:0] fin_res;
	logic [IW-1:0]   id_w;
	logic            id_in_range;
	logic            head_valid;

	assign id_w        = IW'(req.id);
	assign id_in_range = (id_w != '0) && (id_w <= MAX_ID);
	assign head_valid  = (rdata != '0) && (rdata <= MAX_LINK);
	assign slot_free   = !out_valid_q || rsp.ready;

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.result_id = out_res_q;
	assign rsp.ok        = out_ok_q;

	idfl_link_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.LW   (LW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		re      = 1'b0;
		raddr   = '0;
		fin     = 1'b0;
		fin_res = '0;
		fin_ok  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == LAST_IDX) ? END_MARK : LW'(clr_q) + LW'(1);
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					re = 1'b1;
					if ((req.operation == OP_FREE || req.operation == OP_CHECK)
					    && id_in_range) begin
						raddr = AW'(id_w);
					end
					state_d = (req.operation == OP_FIND) ? ST_SCAN : ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				case (op_q)
					OP_ALLOC: begin
						// rdata is the head of the free list
						if (head_valid) begin
							re      = 1'b1;
							raddr   = AW'(rdata);
							state_d = ST_LINK;
						end else begin
							fin = 1'b1;
						end
					end
					OP_FREE: begin
						if (id_ok_q && rdata == ALLOC_MARK) begin
							re      = 1'b1;
							raddr   = '0;
							state_d = ST_HEADRD;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin    = 1'b1;
						fin_ok = id_ok_q && (rdata == ALLOC_MARK);
					end
				endcase
			end
			ST_LINK: begin
				// successor of the popped id becomes the new head
				we      = 1'b1;
				waddr   = '0;
				wdata   = rdata;
				state_d = ST_MARK;
			end
			ST_MARK: begin
				we      = 1'b1;
				waddr   = head_q;
				wdata   = ALLOC_MARK;
				fin     = 1'b1;
				fin_ok  = 1'b1;
				fin_res = ID_W'(head_q);
			end
			ST_HEADRD: begin
				we      = 1'b1;
				waddr   = id_addr_q;
				wdata   = rdata;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				we     = 1'b1;
				waddr  = '0;
				wdata  = LW'(id_addr_q);
				fin    = 1'b1;
				fin_ok = 1'b1;
			end
			ST_SCAN: begin
				// rdata belongs to rd_addr_s1, next address is read meanwhile
				if (rdata == ALLOC_MARK) begin
					fin     = 1'b1;
					fin_ok  = 1'b1;
					fin_res = ID_W'(rd_addr_s1);
				end else if (rd_addr_s1 == LAST_IDX) begin
					fin = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = rd_addr_s1 + AW'(1);
				end
			end
			ST_DONE: begin
				fin     = 1'b1;
				fin_ok  = pend_ok_q;
				fin_res = pend_res_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = slot_free ? ST_IDLE : ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (fin && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q      <= req.operation;
			id_addr_q <= AW'(id_w);
			id_ok_q   <= id_in_range;
		end
		if (state_q == ST_LOOKUP) begin
			head_q <= AW'(rdata);
		end
		if (re) begin
			rd_addr_s1 <= raddr;
		end
		if (fin && slot_free) begin
			out_res_q <= fin_res;
			out_ok_q  <= fin_ok;
		end
		if (fin && !slot_free) begin
			pend_res_q <= fin_res;
			pend_ok_q  <= fin_ok;
		end
	end

endmodule

// ===== hdl/idfl_checker.sv =====
module idfl_checker import idfl_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic [ID_W-1:0] rsp_result_id,
	input logic            rsp_ok
);

	// a stalled response stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// a stalled response keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result_id) && $stable(rsp_ok))
		else $error("response payload changed while stalled");

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// a nonzero identifier only comes with success
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_result_id != '0 |-> rsp_ok)
		else $error("identifier returned on a failed request");

endmodule

bind id_free_list_allocator idfl_checker u_idfl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_result_id(rsp.result_id),
	.rsp_ok       (rsp.ok)
);
